// File: rtl/hill_cipher_block_macros.svh
// Assertion macros shared by the hill cipher block checker.
`ifndef HILL_CIPHER_BLOCK_MACROS_SVH
`define HILL_CIPHER_BLOCK_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define HCB_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define HCB_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds around reset.
`define HCB_ASSERT_ALWAYS(label, clk_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/hcb_pkg.sv
// Shared types, constants and helpers of the hill cipher block.
`timescale 1ns / 1ps

package hcb_pkg;

  localparam int ENTRY_W   = 5;
  localparam int KEY_ROWS  = 4;
  localparam int KEY_ROW_W = 20;
  localparam int ROW_IDX_W = 2;
  localparam int BSIZE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CHAR_W    = 8;
  localparam int OUT_W     = 7;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'd122;
  localparam int ALPHABET = 26;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3   = 3'd4;

  localparam logic [BSIZE_W-1:0]   BSIZE_RESET = 3'd2;
  localparam logic [KEY_ROW_W-1:0] ROW0_RESET  = 20'd67;
  localparam logic [KEY_ROW_W-1:0] ROW1_RESET  = 20'd226;

  typedef logic [KEY_ROW_W-1:0] key_row_t;

  typedef struct packed {
    logic [BSIZE_W-1:0]          block_size;
    key_row_t [KEY_ROWS-1:0]     key;
  } hcb_cfg_t;

  typedef struct packed {
    logic               is_letter;
    logic [ENTRY_W-1:0] value;
  } letter_t;

  // Map a text byte to 0..25 and say whether it is a letter.
  function automatic letter_t classify(input logic [CHAR_W-1:0] c);
    letter_t r;
    r.is_letter = 1'b0;
    r.value     = '0;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r.is_letter = 1'b1;
      r.value     = ENTRY_W'(c - ASCII_UPPER_A);
    end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      r.is_letter = 1'b1;
      r.value     = ENTRY_W'(c - ASCII_LOWER_A);
    end
    return r;
  endfunction

endpackage

// File: rtl/hcb_fifo.sv
// Small register queue between the front and back of the hill cipher block.
`timescale 1ns / 1ps

module hcb_fifo #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/hcb_front.sv
// Front end: configuration registers, letter filter and block assembly.
`timescale 1ns / 1ps

module hcb_front
  import hcb_pkg::*;
#(
  parameter int MAX_DIM = 4,
  parameter int SIZE_W  = $clog2(MAX_DIM + 1),
  parameter int BLK_W   = MAX_DIM * ENTRY_W + SIZE_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_ROW_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_char,
  output logic                 blk_valid,
  input  logic                 blk_ready,
  output logic [BLK_W-1:0]     blk_data,
  output hcb_cfg_t             cfg
);

  localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

  logic [ENTRY_W-1:0] letters [MAX_DIM];
  logic [CNT_W-1:0]   count;
  logic [SIZE_W-1:0]  eff_size;
  letter_t            cls;
  logic               take;
  logic               complete;
  logic [MAX_DIM*ENTRY_W-1:0] blk_letters;

  always_comb begin
    if (cfg.block_size < BSIZE_W'(2)) begin
      eff_size = SIZE_W'(2);
    end else if (cfg.block_size > BSIZE_W'(MAX_DIM)) begin
      eff_size = SIZE_W'(MAX_DIM);
    end else begin
      eff_size = SIZE_W'(cfg.block_size);
    end
  end

  assign cls      = classify(in_char);
  assign in_ready = blk_ready;
  assign take     = in_valid && in_ready && cls.is_letter;
  assign complete = (SIZE_W'(count) + SIZE_W'(1)) >= eff_size;

  // The block goes out with the arriving letter already in its slot.
  always_comb begin
    for (int j = 0; j < MAX_DIM; j++) begin
      blk_letters[j*ENTRY_W +: ENTRY_W] =
        (CNT_W'(j) == count) ? cls.value : letters[j];
    end
  end

  assign blk_valid = in_valid && cls.is_letter && complete;
  assign blk_data  = {eff_size, blk_letters};

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      letters[count] <= cls.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size <= BSIZE_RESET;
      cfg.key[0]     <= ROW0_RESET;
      cfg.key[1]     <= ROW1_RESET;
      cfg.key[2]     <= '0;
      cfg.key[3]     <= '0;
      count          <= '0;
    end else begin
      if (take) begin
        count <= complete ? '0 : count + CNT_W'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BLOCK_SIZE: begin
            cfg.block_size <= cfg_data[BSIZE_W-1:0];
            count          <= '0;
          end
          REG_KEY_ROW0: cfg.key[0] <= cfg_data;
          REG_KEY_ROW1: cfg.key[1] <= cfg_data;
          REG_KEY_ROW2: cfg.key[2] <= cfg_data;
          REG_KEY_ROW3: cfg.key[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/hcb_back.sv
// Back end: row sequencer and mod-26 matrix product pipeline.
`timescale 1ns / 1ps

module hcb_back
  import hcb_pkg::*;
#(
  parameter int MAX_DIM = 4,
  parameter int SIZE_W  = $clog2(MAX_DIM + 1),
  parameter int BLK_W   = MAX_DIM * ENTRY_W + SIZE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  hcb_cfg_t          cfg,
  input  logic              blk_valid,
  output logic              blk_ready,
  input  logic [BLK_W-1:0]  blk_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_char,
  output logic              out_last
);

  localparam int CNT_W   = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int PROD_W  = 2 * ENTRY_W;
  localparam int SUM_W   = PROD_W + $clog2(MAX_DIM);
  // floor(x * RECIP / 2^RSHIFT) equals floor(x / 26) for every sum reached here.
  localparam int RSHIFT  = 16;
  localparam int RECIP   = ((1 << RSHIFT) + ALPHABET - 1) / ALPHABET;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int QP_W    = SUM_W + RECIP_W;
  localparam int Q_W     = QP_W - RSHIFT;

  logic [SIZE_W-1:0]  blk_size;
  logic [ENTRY_W-1:0] blk_letter [MAX_DIM];
  logic [CNT_W-1:0]   row;
  logic               row_last;
  logic               adv;

  logic               s1_valid, s1_last;
  logic [PROD_W-1:0]  s1_prod [MAX_DIM];
  logic               s2_valid, s2_last;
  logic [SUM_W-1:0]   s2_sum;
  logic               s3_valid, s3_last;
  logic [SUM_W-1:0]   s3_sum;
  logic [QP_W-1:0]    s3_qp;

  logic [SUM_W-1:0]   sum_next;
  logic [Q_W-1:0]     quot;
  logic [SUM_W-1:0]   rem;

  assign blk_size = blk_data[BLK_W-1 -: SIZE_W];
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_unpack
    assign blk_letter[j] = blk_data[j*ENTRY_W +: ENTRY_W];
  end

  // Whole pipeline moves together; stall only when the output is held.
  assign adv       = !out_valid || out_ready;
  assign row_last  = (SIZE_W'(row) + SIZE_W'(1)) >= blk_size;
  assign blk_ready = adv && row_last;

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      sum_next = sum_next + SUM_W'(s1_prod[j]);
    end
  end

  assign quot = s3_qp[QP_W-1:RSHIFT];
  assign rem  = s3_sum - (SUM_W'(quot) * SUM_W'(ALPHABET));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= row_last;
      for (int j = 0; j < MAX_DIM; j++) begin
        if (SIZE_W'(j) < blk_size) begin
          s1_prod[j] <= PROD_W'(cfg.key[ROW_IDX_W'(row)][j*ENTRY_W +: ENTRY_W]) *
                        PROD_W'(blk_letter[j]);
        end else begin
          s1_prod[j] <= '0;
        end
      end
      s2_last  <= s1_last;
      s2_sum   <= sum_next;
      s3_last  <= s2_last;
      s3_sum   <= s2_sum;
      s3_qp    <= QP_W'(s2_sum) * QP_W'(RECIP);
      out_last <= s3_last;
      out_char <= OUT_W'(ASCII_LOWER_A) + OUT_W'(rem[ENTRY_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= blk_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      if (blk_valid) begin
        row <= row_last ? '0 : row + CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/hill_cipher_block.sv
// Top level of the hill cipher block: front end, block queue and back end.
//
//   channel   direction  signals                              transfer carries
//   s_axis    in         tvalid tready tdata[7:0]             one text byte
//   m_axis    out        tvalid tready tdata[7:0] tlast       one cipher letter
//   cfg       in         valid ready index[2:0] data[19:0]    one register write
//
// Throughput is one byte per cycle on s_axis and one letter per cycle on
// m_axis while neither stalls; unstalled, the back end takes one key row
// per cycle through a four-stage multiply/reduce pipeline (s1 products,
// s2 sum, s3 reciprocal product, output register) after the block queue.
// Reset (rst, synchronous) restores block size 2 and the default key and
// empties the letter buffer, queue and pipeline.
// s_axis stalls only when the two-entry block queue is full; m_axis stalls
// freeze the back end while the front collects letters until the queue fills.
`timescale 1ns / 1ps

module hill_cipher_block
  import hcb_pkg::*;
#(
  parameter int MAX_DIM = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // Text bytes in.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] in_char
  // Cipher letters out.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic                 m_axis_tlast,   // block_last
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_ROW_W-1:0] cfg_data
);

  localparam int SIZE_W = $clog2(MAX_DIM + 1);
  localparam int BLK_W  = MAX_DIM * ENTRY_W + SIZE_W;

  hcb_cfg_t         cfg;
  logic             fq_valid, fq_ready;
  logic [BLK_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [BLK_W-1:0] qb_data;
  logic [OUT_W-1:0] out_char;

  // Registers take a write on any cycle.
  assign cfg_ready = 1'b1;

  hcb_front #(
    .MAX_DIM (MAX_DIM),
    .SIZE_W  (SIZE_W),
    .BLK_W   (BLK_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .blk_valid (fq_valid),
    .blk_ready (fq_ready),
    .blk_data  (fq_data),
    .cfg       (cfg)
  );

  // Hold up to two complete blocks between filter and multiplier.
  hcb_fifo #(
    .WIDTH (BLK_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  hcb_back #(
    .MAX_DIM (MAX_DIM),
    .SIZE_W  (SIZE_W),
    .BLK_W   (BLK_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .blk_valid (qb_valid),
    .blk_ready (qb_ready),
    .blk_data  (qb_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: rtl/hcb_checker.sv
// Port-level checker for the hill cipher block, bound to the top level.
`timescale 1ns / 1ps
`include "hill_cipher_block_macros.svh"

module hcb_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A waiting text byte stays offered and unchanged.
  `HCB_ASSERT_NEXT(a_in_hold, clk, rst, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata), "input changed while stalled")

  // A held letter keeps its value and its block flag.
  `HCB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

  // Every result is a lowercase letter.
  `HCB_ASSERT_NOW(a_out_lower, clk, rst, m_axis_tvalid, m_axis_tdata >= 8'd97 && m_axis_tdata <= 8'd122, "output is not a lowercase letter")

  // Reset empties the pipeline.
  `HCB_ASSERT_ALWAYS(a_rst_clear, clk, $past(rst), !m_axis_tvalid, "output valid right after reset")

  // Register writes never wait.
  `HCB_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind hill_cipher_block hcb_checker u_hcb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
